// File: rtl/lcsd_pkg.sv
// ---------------------------------------------------------------------------
// lcsd_pkg - shared types and constants for the LED cube scan driver
// Action codes, cube geometry, anode wiring tables and bit-order helpers.
// ---------------------------------------------------------------------------
package lcsd_pkg;

  localparam int unsigned CoordW  = 3;
  localparam int unsigned NumLay  = 1 << CoordW;        // layers, rows, columns
  localparam int unsigned WordW   = NumLay * NumLay;    // LEDs per layer
  localparam int unsigned ByteW   = 8;
  localparam int unsigned IdxW    = 4;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [WordW-1:0]  layer_word_t;
  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [IdxW-1:0]   byte_idx_t;

  localparam logic [2:0] ACT_SET_LED     = 3'd0;
  localparam logic [2:0] ACT_CLR_LED     = 3'd1;
  localparam logic [2:0] ACT_SET_LAYER   = 3'd2;
  localparam logic [2:0] ACT_CLR_LAYER   = 3'd3;
  localparam logic [2:0] ACT_CLR_COLUMN  = 3'd4;
  localparam logic [2:0] ACT_CLR_ALL     = 3'd5;
  localparam logic [2:0] ACT_REFRESH     = 3'd6;

  localparam byte_idx_t CATHODE_IDX = 4'd0;
  localparam byte_idx_t LAST_IDX    = 4'd8;

  // anode wiring: bit position b of a byte reads column ANODE_X[b],
  // byte k of the anode stream reads row ANODE_Y[k]
  localparam coord_t ANODE_X [NumLay] = '{3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd7};
  localparam coord_t ANODE_Y [NumLay] = '{3'd0, 3'd2, 3'd5, 3'd7, 3'd6, 3'd4, 3'd3, 3'd1};
  localparam coord_t CATHODE_MAP [NumLay] =
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

  typedef struct packed {
    logic   valid;
    logic [2:0] action;
    coord_t x;
    coord_t y;
    coord_t z;
  } lcsd_edit_t;

  function automatic byte_t cathode_byte(input coord_t layer);
    byte_t v;
    v = '0;
    for (int p = 0; p < NumLay; p++) begin
      if (CATHODE_MAP[p] == layer) v[ByteW-1-p] = 1'b1;
    end
    return v;
  endfunction

  // Reorder a layer word into shift order: anode byte k in bits [63-8k -: 8]
  function automatic layer_word_t shift_order(input layer_word_t w);
    layer_word_t s;
    s = '0;
    for (int k = 0; k < NumLay; k++) begin
      for (int b = 0; b < NumLay; b++) begin
        s[WordW-1-(k*ByteW)-b] = w[{ANODE_Y[k], ANODE_X[b]}];
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/led_cube_layer_scan_driver_top.sv
// ---------------------------------------------------------------------------
// led_cube_layer_scan_driver_top - 8x8x8 LED cube frame store and scan-out
// Edit transactions change the frame store; a refresh transaction streams
// nine shift bytes for the current scan layer and advances the layer on acceptance.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one action per transaction.
//   Edit actions finish in the accepting cycle and produce no output; with
//   no refresh in flight in_ready stays high, one edit per cycle.
//   A refresh copies the scan layer word into a 64-bit shift register.
//   The output channel then carries the cathode byte (index 0), followed
//   by anode bytes 1 to 8, one per cycle while out_ready is high;
//   latch_now marks byte 8.
//   After a refresh is accepted, in_ready is low until byte 8 enters the
//   output register, so no new action is taken while the byte-serial shift
//   register is emptied. A stall on out_ready holds the output register
//   and freezes the shift register.
//   Reset clears every LED and sets the scan layer to 0.
// ---------------------------------------------------------------------------
module led_cube_layer_scan_driver_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_action,
  input  logic [2:0] in_x_pos,
  input  logic [2:0] in_y_pos,
  input  logic [2:0] in_z_pos,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_shift_byte,
  output logic [3:0] out_byte_index,
  output logic [2:0] out_layer_shown,
  output logic       out_latch_now
);
  import lcsd_pkg::*;

  logic        in_fire;
  logic        busy;
  logic        start;
  lcsd_edit_t  edit;
  coord_t      scan_layer;
  layer_word_t rd_word;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign start    = in_fire && (in_action == ACT_REFRESH);

  assign edit.valid  = in_fire;
  assign edit.action = in_action;
  assign edit.x      = in_x_pos;
  assign edit.y      = in_y_pos;
  assign edit.z      = in_z_pos;

  lcsd_frame_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .edit     (edit),
    .rd_layer (scan_layer),
    .rd_word  (rd_word)
  );

  lcsd_scan_serializer u_scan (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .word            (rd_word),
    .scan_layer      (scan_layer),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_shift_byte  (out_shift_byte),
    .out_byte_index  (out_byte_index),
    .out_layer_shown (out_layer_shown),
    .out_latch_now   (out_latch_now)
  );

endmodule

// File: rtl/lcsd_frame_store.sv
// ---------------------------------------------------------------------------
// lcsd_frame_store - 8 layers x 64 LED bits with edit logic
// Applies one edit per cycle and offers one layer word on a read port.
// ---------------------------------------------------------------------------
module lcsd_frame_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcsd_pkg::lcsd_edit_t edit,
  input  lcsd_pkg::coord_t     rd_layer,
  output lcsd_pkg::layer_word_t rd_word
);
  import lcsd_pkg::*;

  layer_word_t store_r   [NumLay];
  layer_word_t store_nxt [NumLay];
  layer_word_t led_mask;

  assign led_mask = layer_word_t'(1) << {edit.y, edit.x};
  assign rd_word  = store_r[rd_layer];

  always_comb begin
    for (int k = 0; k < NumLay; k++) begin
      store_nxt[k] = store_r[k];
      if (edit.valid) begin
        case (edit.action)
          ACT_SET_LED:    if (coord_t'(k) == edit.z) store_nxt[k] = store_r[k] | led_mask;
          ACT_CLR_LED:    if (coord_t'(k) == edit.z) store_nxt[k] = store_r[k] & ~led_mask;
          ACT_SET_LAYER:  if (coord_t'(k) == edit.z) store_nxt[k] = '1;
          ACT_CLR_LAYER:  if (coord_t'(k) == edit.z) store_nxt[k] = '0;
          ACT_CLR_COLUMN: store_nxt[k] = store_r[k] & ~led_mask;
          ACT_CLR_ALL:    store_nxt[k] = '0;
          default:        store_nxt[k] = store_r[k];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NumLay; k++) begin
      if (!rst_n) begin
        store_r[k] <= '0;
      end else begin
        store_r[k] <= store_nxt[k];
      end
    end
  end

endmodule

// File: rtl/lcsd_scan_serializer.sv
// ---------------------------------------------------------------------------
// lcsd_scan_serializer - byte-serial scan-out of one layer
// Holds the scan layer, loads a layer word into a shift register and emits
// the cathode byte then eight anode bytes through an output register.
// ---------------------------------------------------------------------------
module lcsd_scan_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  lcsd_pkg::layer_word_t word,
  output lcsd_pkg::coord_t      scan_layer,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lcsd_pkg::byte_t       out_shift_byte,
  output lcsd_pkg::byte_idx_t   out_byte_index,
  output lcsd_pkg::coord_t      out_layer_shown,
  output logic                  out_latch_now
);
  import lcsd_pkg::*;

  logic        busy_r;
  byte_idx_t   idx_r;
  layer_word_t shreg_r;
  coord_t      layer_r;
  coord_t      scan_layer_r;
  logic        out_valid_r;
  byte_t       out_byte_r;
  byte_idx_t   out_idx_r;
  coord_t      out_layer_r;
  logic        out_latch_r;
  logic        emit;

  assign emit = busy_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      idx_r        <= CATHODE_IDX;
      scan_layer_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (start) begin
        busy_r       <= 1'b1;
        idx_r        <= CATHODE_IDX;
        scan_layer_r <= scan_layer_r + coord_t'(1);
      end else if (emit) begin
        idx_r <= idx_r + byte_idx_t'(1);
        if (idx_r == LAST_IDX) busy_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      shreg_r <= shift_order(word);
      layer_r <= scan_layer_r;
    end else if (emit && idx_r != CATHODE_IDX) begin
      shreg_r <= shreg_r << ByteW;
    end
    if (emit) begin
      out_byte_r  <= (idx_r == CATHODE_IDX) ? cathode_byte(layer_r)
                                            : shreg_r[WordW-1 -: ByteW];
      out_idx_r   <= idx_r;
      out_layer_r <= layer_r;
      out_latch_r <= (idx_r == LAST_IDX);
    end
  end

  assign scan_layer      = scan_layer_r;
  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_shift_byte  = out_byte_r;
  assign out_byte_index  = out_idx_r;
  assign out_layer_shown = out_layer_r;
  assign out_latch_now   = out_latch_r;

endmodule

// File: rtl/lcsd_checker.sv
// ---------------------------------------------------------------------------
// lcsd_checker - port-level assertions for the LED cube scan driver
// Checks output hold under stall, latch marking, cathode content and
// refresh occupancy; bound to the top level.
// ---------------------------------------------------------------------------
module lcsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_shift_byte,
  input logic [3:0] out_byte_index,
  input logic [2:0] out_layer_shown,
  input logic       out_latch_now
);
  import lcsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_shift_byte)
      && $stable(out_byte_index) && $stable(out_layer_shown))
    else $error("output transaction changed while stalled");

  a_latch_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_latch_now == (out_byte_index == LAST_IDX)))
    else $error("latch flag not on the last byte");

  a_cathode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_index == CATHODE_IDX
      |-> out_shift_byte == (8'h80 >> out_layer_shown))
    else $error("cathode byte does not select the shown layer");

  a_refresh_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_REFRESH |=> !in_ready)
    else $error("input taken during refresh scan-out");

endmodule

bind led_cube_layer_scan_driver_top lcsd_checker u_lcsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_shift_byte  (out_shift_byte),
  .out_byte_index  (out_byte_index),
  .out_layer_shown (out_layer_shown),
  .out_latch_now   (out_latch_now)
);
